FILE: rtl/core/ple_pkg.sv
package ple_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned CMD_W       = 3;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned POS_W       = 8;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_OUT_W = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_POS   = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_POS   = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

FILE: rtl/core/ple_ctrl.sv
module ple_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ple_pkg::ctrl_cmd_t cmd_o
);
  import ple_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTH
  a_load_to_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_EXEC))
    else $error("accepted request did not move to execute");

  a_exec_sets_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_q)
    else $error("executed request produced no result beat");

  a_wait_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) && !out_free |=> (state_q == S_EXEC) && out_valid_q)
    else $error("execute left while result register was occupied");
`endif

endmodule

FILE: rtl/core/ple_dp.sv
module ple_dp #(
  parameter int unsigned DEPTH      = ple_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ple_pkg::ctrl_cmd_t                   cmd_i,
  input  logic [ple_pkg::CMD_W-1:0]            req_cmd_i,
  input  logic signed [ple_pkg::VALUE_W-1:0]   req_value_i,
  input  logic [ple_pkg::POS_W-1:0]            req_position_i,
  output logic [ple_pkg::STATUS_W-1:0]         status_o,
  output logic [ple_pkg::COUNT_OUT_W-1:0]      entry_count_o
);
  import ple_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);

  logic [CMD_W-1:0]            cmd_q;
  logic [DATA_WIDTH-1:0]       value_q;
  logic [POS_W-1:0]            pos_q;
  logic [CNT_W-1:0]            count_q, count_d;
  logic [STATUS_W-1:0]         res_status_q;
  logic [CNT_W-1:0]            res_count_q;
  logic [DATA_WIDTH-1:0]       entries_q [DEPTH];

  logic signed [63:0]          value_ext;
  logic [COUNT_OUT_W-1:0]      pos9, cnt9, pos_m1;
  logic [CNT_W-1:0]            cnt_m1;
  logic [IDX_W-1:0]            idx;
  logic                        do_ins, do_del;
  status_e                     status;

  assign value_ext = 64'(req_value_i);
  assign pos9      = COUNT_OUT_W'(pos_q);
  assign cnt9      = COUNT_OUT_W'(count_q);
  assign pos_m1    = pos9 - COUNT_OUT_W'(1);
  assign cnt_m1    = count_q - CNT_W'(1);

  always_comb begin
    status = ST_DONE;
    do_ins = 1'b0;
    do_del = 1'b0;
    idx    = '0;
    unique case (cmd_e'(cmd_q))
      CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
        if (count_q == CNT_W'(DEPTH)) begin
          status = ST_FULL;
        end else if (cmd_e'(cmd_q) == CMD_INS_FRONT) begin
          do_ins = 1'b1;
        end else if (cmd_e'(cmd_q) == CMD_INS_BACK) begin
          do_ins = 1'b1;
          idx    = count_q[IDX_W-1:0];
        end else if (pos9 == '0 || pos9 > cnt9 + COUNT_OUT_W'(1)) begin
          status = ST_BADPOS;
        end else begin
          do_ins = 1'b1;
          idx    = pos_m1[IDX_W-1:0];
        end
      end
      CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS: begin
        if (count_q == '0) begin
          status = ST_EMPTY;
        end else if (cmd_e'(cmd_q) == CMD_DEL_FRONT) begin
          do_del = 1'b1;
        end else if (cmd_e'(cmd_q) == CMD_DEL_BACK) begin
          do_del = 1'b1;
          idx    = cnt_m1[IDX_W-1:0];
        end else if (pos9 == '0 || pos9 > cnt9) begin
          status = ST_BADPOS;
        end else begin
          do_del = 1'b1;
          idx    = pos_m1[IDX_W-1:0];
        end
      end
      default: begin
        status = ST_DONE;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_del) begin
      count_d = cnt_m1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q   <= req_cmd_i;
      value_q <= value_ext[DATA_WIDTH-1:0];
      pos_q   <= req_position_i;
    end
    if (cmd_i.exec) begin
      res_status_q <= status;
      res_count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd_i.exec && do_ins) begin
        if (IDX_W'(i) == idx) begin
          entries_q[i] <= value_q;
        end else if (i > 0 && IDX_W'(i) > idx) begin
          entries_q[i] <= entries_q[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd_i.exec && do_del) begin
        if (i < DEPTH - 1 && IDX_W'(i) >= idx) begin
          entries_q[i] <= entries_q[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  assign status_o      = res_status_q;
  assign entry_count_o = COUNT_OUT_W'(res_count_q);

`ifndef SYNTH
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count exceeds list depth");

  a_count_only_on_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec |=> $stable(count_q))
    else $error("entry count changed outside of execute");

  a_single_op : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(do_ins && do_del))
    else $error("insert and delete decoded together");
`endif

endmodule

FILE: rtl/core/positional_list_engine.sv
// Ordered list of up to DEPTH signed words with positional insert and delete.
// Request channel: in_valid_i with cmd_i, value_i and position_i; a beat is
// taken when in_valid_i is high and in_stall_o is low. Response channel:
// out_valid_o with status_o and entry_count_o; a beat leaves when
// out_valid_o is high and out_stall_i is low. Every request gives exactly
// one response beat carrying its status and the entry count afterwards.
// The block works on one request at a time: a request is registered at
// acceptance in S_IDLE, executed in S_EXEC once the output register is
// free, and its response is registered as it executes. The list shifts all
// later entries by one place in that single execute step, so a new request
// is not taken until the previous one has executed.
// The response sits in an output register; a new request is accepted while
// it waits, but execution holds until the receiver takes the older beat.
// Reset empties the list at once; stored words are not cleared and are
// never shown on any port.
module positional_list_engine #(
  parameter int unsigned DEPTH      = ple_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ple_pkg::CMD_W-1:0]          cmd_i,
  input  logic signed [ple_pkg::VALUE_W-1:0] value_i,
  input  logic [ple_pkg::POS_W-1:0]          position_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ple_pkg::STATUS_W-1:0]       status_o,
  output logic [ple_pkg::COUNT_OUT_W-1:0]    entry_count_o
);
  import ple_pkg::*;

  ctrl_cmd_t ctrl_cmd;

  ple_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (ctrl_cmd)
  );

  ple_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctrl_cmd),
    .req_cmd_i      (cmd_i),
    .req_value_i    (value_i),
    .req_position_i (position_i),
    .status_o       (status_o),
    .entry_count_o  (entry_count_o)
  );

endmodule

FILE: verif/list_response_checker.sv
module list_response_checker #(
  parameter int unsigned DEPTH = ple_pkg::DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [ple_pkg::CMD_W-1:0]       cmd_i,
  input  logic [ple_pkg::POS_W-1:0]       position_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [ple_pkg::STATUS_W-1:0]    status_i,
  input  logic [ple_pkg::COUNT_OUT_W-1:0] entry_count_i,
  output int                              failures_o,
  output int                              pending_o,
  output int                              held_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ple_pkg::*;

  typedef struct packed {
    status_e                status;
    logic [COUNT_OUT_W-1:0] entry_count;
  } list_reply_t;

  list_reply_t reply_queue[$];
  int unsigned held = 0;
  int failures = 0;
  int pending = 0;

  assign failures_o = failures;
  assign pending_o  = pending;
  assign held_o     = int'(held);

  function automatic list_reply_t apply_request(input logic [CMD_W-1:0] op,
                                                input logic [POS_W-1:0] pos);
    list_reply_t reply;
    int unsigned slot;
    reply.status = ST_DONE;
    slot = 32'(pos);
    case (op)
      CMD_INS_FRONT, CMD_INS_BACK: begin
        if (held >= DEPTH) reply.status = ST_FULL;
        else held++;
      end
      CMD_INS_POS: begin
        if (held >= DEPTH) reply.status = ST_FULL;
        else if (slot < 1 || slot > held + 1) reply.status = ST_BADPOS;
        else held++;
      end
      CMD_DEL_FRONT, CMD_DEL_BACK: begin
        if (held == 0) reply.status = ST_EMPTY;
        else held--;
      end
      CMD_DEL_POS: begin
        if (held == 0) reply.status = ST_EMPTY;
        else if (slot < 1 || slot > held) reply.status = ST_BADPOS;
        else held--;
      end
      default: begin
      end
    endcase
    reply.entry_count = COUNT_OUT_W'(held);
    return reply;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_reply_t want;
    if (!rst_ni) begin
      held = 0;
      reply_queue.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (reply_queue.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: response beat with none expected: status %0d count %0d",
                     $time, status_i, entry_count_i);
        end else begin
          want = reply_queue.pop_front();
          if (status_i !== want.status || entry_count_i !== want.entry_count) begin
            failures++;
            if (failures <= 10)
              $display("%0t: mismatch: expected status %s count %0d, got status %0d count %0d",
                       $time, want.status.name(), want.entry_count, status_i,
                       entry_count_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) reply_queue.push_back(apply_request(cmd_i, position_i));
    end
    pending = reply_queue.size();
  end

endmodule

FILE: verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ple_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd7;
  localparam logic [VALUE_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [VALUE_W-1:0] WORD_ONES = 32'hffff_ffff;
  localparam logic [POS_W-1:0] POS_TOP = 8'hff;

  logic                   clk_i = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [CMD_W-1:0]       cmd = CMD_INS_FRONT;
  logic [VALUE_W-1:0]     value = '0;
  logic [POS_W-1:0]       position = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [STATUS_W-1:0]    status;
  logic [COUNT_OUT_W-1:0] entry_count;

  int failures;
  int pending;
  int held;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  positional_list_engine uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .cmd_i         (cmd),
    .value_i       (value),
    .position_i    (position),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .entry_count_o (entry_count)
  );

  list_response_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .cmd_i         (cmd),
    .position_i    (position),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .status_i      (status),
    .entry_count_i (entry_count),
    .failures_o    (failures),
    .pending_o     (pending),
    .held_o        (held)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic next_slot();
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  task automatic drive_beat(input logic [CMD_W-1:0] op, input logic [VALUE_W-1:0] word,
                            input logic [POS_W-1:0] pos);
    in_valid <= 1'b1;
    cmd      <= op;
    value    <= word;
    position <= pos;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic directed(input logic [CMD_W-1:0] op, input logic [VALUE_W-1:0] word,
                          input logic [POS_W-1:0] pos);
    next_slot();
    drive_beat(op, word, pos);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic random_request(input int fill_pct);
    logic [CMD_W-1:0]   op;
    logic [VALUE_W-1:0] word;
    logic [POS_W-1:0]   pos;
    bit                 grows;
    next_slot();
    grows = ($urandom_range(99) < fill_pct);
    if ($urandom_range(99) < 2) op = $urandom_range(1) ? CMD_UNUSED_A : CMD_UNUSED_B;
    else if (grows) begin
      case ($urandom_range(2))
        0: op = CMD_INS_FRONT;
        1: op = CMD_INS_BACK;
        default: op = CMD_INS_POS;
      endcase
    end else begin
      case ($urandom_range(2))
        0: op = CMD_DEL_FRONT;
        1: op = CMD_DEL_BACK;
        default: op = CMD_DEL_POS;
      endcase
    end
    if ($urandom_range(99) < 12) begin
      case ($urandom_range(2))
        0: pos = '0;
        1: pos = POS_W'(grows ? held + 2 : held + 1);
        default: pos = POS_W'($urandom_range(255));
      endcase
    end else if (grows) pos = POS_W'($urandom_range(held + 1, 1));
    else pos = (held == 0) ? POS_W'(1) : POS_W'($urandom_range(held, 1));
    case ($urandom_range(19))
      0: word = WORD_MIN;
      1: word = WORD_MAX;
      2: word = '0;
      3: word = WORD_ONES;
      default: word = $urandom;
    endcase
    drive_beat(op, word, pos);
  endtask

  task automatic random_phase(input int items);
    int left;
    int run;
    int fill_pct;
    left = items;
    fill_pct = 80;
    while (left > 0) begin
      run = $urandom_range(60, 20);
      if (run > left) run = left;
      repeat (run) random_request(fill_pct);
      left -= run;
      fill_pct = 100 - fill_pct;
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    directed(CMD_DEL_FRONT, '0, 8'd1);
    directed(CMD_DEL_BACK, '0, 8'd1);
    directed(CMD_DEL_POS, '0, 8'd1);
    directed(CMD_INS_POS, WORD_MAX, 8'd0);
    directed(CMD_INS_POS, WORD_MAX, 8'd2);
    directed(CMD_INS_POS, WORD_MAX, POS_TOP);
    directed(CMD_INS_POS, WORD_MIN, 8'd1);
    directed(CMD_DEL_POS, '0, 8'd1);
    directed(CMD_INS_FRONT, WORD_MAX, POS_TOP);
    directed(CMD_INS_BACK, '0, 8'd0);
    directed(CMD_INS_POS, WORD_ONES, 8'd3);
    directed(CMD_DEL_POS, WORD_ONES, 8'd0);
    directed(CMD_DEL_POS, '0, 8'd4);
    directed(CMD_DEL_POS, '0, POS_TOP);
    directed(CMD_UNUSED_A, WORD_MIN, 8'd1);
    directed(CMD_UNUSED_B, WORD_ONES, POS_TOP);
    directed(CMD_DEL_BACK, '0, 8'd0);
    directed(CMD_DEL_FRONT, '0, 8'd0);
    directed(CMD_DEL_POS, WORD_MAX, 8'd1);
    drain();

    send_idle_pct = 31;
    recv_idle_pct = 58;
    random_phase(545);
    send_idle_pct = 58;
    recv_idle_pct = 31;
    random_phase(545);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(545);

    repeat (10) @(posedge clk_i);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
